### rtl/core/assert_macros.svh
// Assertion macros shared by the cache model RTL.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, switched off while reset is high.
`define SALRU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SALRU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/salru_pkg.sv
// Types, codes and default sizes for the set-associative LRU cache model.
// No dependencies; used by salru_way_sel and set_assoc_lru_cache_model.
package salru_pkg;

  localparam int MAX_SET_BITS_DEF = 6;
  localparam int NUM_WAYS_DEF     = 8;
  localparam int COUNT_WIDTH_DEF  = 32;

  localparam int ADDR_W      = 64;
  localparam int TAG_W       = 64;
  localparam int TOTAL_W     = 32;
  localparam int WAY_FIELD_W = 4;   // holds a way number for up to 16 ways
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

  localparam logic KIND_SINGLE = 1'b0;
  localparam logic KIND_MODIFY = 1'b1;

  typedef enum logic [1:0] {
    OC_HIT   = 2'd0,
    OC_FILL  = 2'd1,
    OC_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              kind;
  } cmd_t;

  typedef struct packed {
    outcome_t           outcome;
    logic               last_of_run;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
    logic [TOTAL_W-1:0] eviction_total;
  } res_t;

  // Lookup decision handed from the way selector to the update stage.
  typedef struct packed {
    logic [WAY_FIELD_W-1:0] way;
    outcome_t               outcome;
  } pick_t;

endpackage

### rtl/core/salru_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/salru_way_sel.sv
// Lookup stage: tag compare, first free way and LRU victim over one set row.
// Depends on salru_pkg and assert_macros.svh.
`include "assert_macros.svh"

module salru_way_sel #(
  parameter int NUM_WAYS = salru_pkg::NUM_WAYS_DEF,
  parameter int RANK_W   = 3,
  parameter int NW_W     = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic [NUM_WAYS-1:0][salru_pkg::TAG_W-1:0] tags,
  input  logic [NUM_WAYS-1:0]              valid,
  input  logic [NUM_WAYS-1:0][RANK_W-1:0]  rank,
  input  logic [salru_pkg::TAG_W-1:0]      tag,
  input  logic [NW_W-1:0]                  ways_eff,
  output salru_pkg::pick_t                 pick
);
  import salru_pkg::*;

  logic                   hit_any;
  logic                   free_any;
  logic [WAY_FIELD_W-1:0] hit_way;
  logic [WAY_FIELD_W-1:0] free_way;
  logic [WAY_FIELD_W-1:0] old_way;
  logic [RANK_W-1:0]      old_rank;
  pick_t                  pick_next;

  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_way  = '0;
    free_way = '0;
    old_way  = '0;
    old_rank = rank[0];
    // Highest way first so the lowest matching way wins.
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (NW_W'(w) < ways_eff) begin
        if (valid[w] && tags[w] == tag) begin
          hit_any = 1'b1;
          hit_way = WAY_FIELD_W'(w);
        end
        if (!valid[w]) begin
          free_any = 1'b1;
          free_way = WAY_FIELD_W'(w);
        end
      end
    end
    // Lowest rank in use; ties go to the lower way.
    for (int w = 1; w < NUM_WAYS; w++) begin
      if (NW_W'(w) < ways_eff && rank[w] < old_rank) begin
        old_rank = rank[w];
        old_way  = WAY_FIELD_W'(w);
      end
    end
    priority if (hit_any) begin
      pick_next.way     = hit_way;
      pick_next.outcome = OC_HIT;
    end else if (free_any) begin
      pick_next.way     = free_way;
      pick_next.outcome = OC_FILL;
    end else begin
      pick_next.way     = old_way;
      pick_next.outcome = OC_EVICT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pick <= pick_next;
    end
  end

  `SALRU_ASSERT(a_hit_kept, en && hit_any |=> pick.outcome == OC_HIT, "hit lost in lookup")
  `SALRU_ASSERT(a_way_in_use, en |=> (int'(pick.way) < NUM_WAYS), "picked way beyond set")
  `SALRU_ASSERT(a_evict_full, en && !hit_any && free_any |=> pick.outcome == OC_FILL,
                "free way not filled first")

endmodule

### rtl/core/set_assoc_lru_cache_model.sv
// Top level: set-associative LRU tag model with hit, miss and eviction counters.
// Depends on salru_pkg, salru_ram, salru_way_sel and assert_macros.svh.
//
//  port group          dir  handshake                    payload
//  start/busy/cmd      in   start & !busy                address, kind
//  done/res            out  done strobe, one cycle       outcome, last_of_run, totals
//  cfg_valid/cfg_ready in   cfg_valid & cfg_ready        cfg_index, cfg_data
//
// Each access has a lookup state on the set row read from RAM, then an update state
// for the rank update and row write-back, with the result strobed on done in it.
// A single command makes one access; a modify makes two (the second reuses the row).
// A new command is taken in the cycle of the last result; one for the same set taken
// then forwards the row being written instead of reading the RAM.
// Synchronous reset clears counters, set/block bits and row-valid flags, sets ways to 1;
// a set not yet written reads as empty with ranks equal to way numbers.
// The result side cannot stall; cfg_ready is always high.
`include "assert_macros.svh"

module set_assoc_lru_cache_model #(
  parameter int MAX_SET_BITS = salru_pkg::MAX_SET_BITS_DEF,
  parameter int NUM_WAYS     = salru_pkg::NUM_WAYS_DEF,
  parameter int COUNT_WIDTH  = salru_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  salru_pkg::cmd_t                  cmd,
  output logic                             done,
  output salru_pkg::res_t                  res,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [salru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0] cfg_data
);
  import salru_pkg::*;

  localparam int SETS   = 1 << MAX_SET_BITS;
  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int RANK_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int NW_W   = $clog2(NUM_WAYS + 1);
  localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int ROW_W  = NUM_WAYS * (TAG_W + 1 + RANK_W);

  state_t state, state_next;

  logic [2:0] set_bits_cfg;
  logic [4:0] block_bits_cfg;
  logic [3:0] ways_cfg;

  logic [2:0]        set_bits_eff;
  logic [NW_W-1:0]   ways_eff;
  logic [SET_W-1:0]  set_cmd;
  logic [TAG_W-1:0]  tag_cmd;
  logic [ADDR_W-1:0] addr_shift;
  logic [5:0]        tag_shift;

  logic             accept;
  logic             look_en;
  logic             mem_we;
  logic             last_run;
  logic             kind_q;
  logic             second;
  logic             fwd;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic [SETS-1:0]  row_init;

  logic [COUNT_WIDTH-1:0] hit_cnt;
  logic [COUNT_WIDTH-1:0] miss_cnt;
  logic [COUNT_WIDTH-1:0] evict_cnt;

  logic [ROW_W-1:0] rd_flat;
  logic [ROW_W-1:0] wr_flat;

  logic [NUM_WAYS-1:0][TAG_W-1:0]  rd_tags, cur_tags, row_tags, new_tags;
  logic [NUM_WAYS-1:0]             rd_valid, cur_valid, row_valid, new_valid;
  logic [NUM_WAYS-1:0][RANK_W-1:0] rd_rank, cur_rank, row_rank, new_rank, reset_rank;

  pick_t             pick;
  logic [WAY_W-1:0]  pick_way;
  logic [RANK_W-1:0] pick_rank;
  logic [RANK_W-1:0] top_rank;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits_cfg   <= '0;
      block_bits_cfg <= '0;
      ways_cfg       <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SET_BITS:   set_bits_cfg   <= cfg_data[2:0];
        REG_BLOCK_BITS: block_bits_cfg <= cfg_data[4:0];
        REG_WAYS:       ways_cfg       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(set_bits_cfg) > MAX_SET_BITS) begin
      set_bits_eff = 3'(MAX_SET_BITS);
    end else begin
      set_bits_eff = set_bits_cfg;
    end
    if (ways_cfg == 4'd0) begin
      ways_eff = NW_W'(1);
    end else if (int'(ways_cfg) > NUM_WAYS) begin
      ways_eff = NW_W'(NUM_WAYS);
    end else begin
      ways_eff = NW_W'(ways_cfg);
    end
  end

  // Address split for the incoming command
  assign addr_shift = cmd.address >> block_bits_cfg;
  assign set_cmd    = addr_shift[SET_W-1:0] & ~({SET_W{1'b1}} << set_bits_eff);
  assign tag_shift  = 6'(set_bits_eff) + 6'(block_bits_cfg);
  assign tag_cmd    = cmd.address >> tag_shift;

  // ---------------- control ----------------
  assign last_run = (kind_q == KIND_SINGLE) || second;

  always_comb begin
    busy    = 1'b0;
    done    = 1'b0;
    look_en = 1'b0;
    mem_we  = 1'b0;
    unique case (state)
      ST_IDLE: ;
      ST_LOOK: begin
        busy    = 1'b1;
        look_en = 1'b1;
      end
      ST_UPD: begin
        busy   = !last_run;
        done   = 1'b1;
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_LOOK;
      ST_LOOK: state_next = ST_UPD;
      ST_UPD: begin
        if (!last_run || accept) begin
          state_next = ST_LOOK;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      second <= 1'b0;
      fwd    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        second <= 1'b0;
        // row being written now is the one this command needs
        fwd    <= (state == ST_UPD) && (set_cmd == set_q);
      end else if (state == ST_UPD && !last_run) begin
        second <= 1'b1;
        fwd    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= cmd.kind;
      set_q  <= set_cmd;
      tag_q  <= tag_cmd;
    end
  end

  // ---------------- set row storage ----------------
  salru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (set_q),
    .wdata (wr_flat),
    .raddr (set_cmd),
    .rdata (rd_flat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
    end else if (mem_we) begin
      row_init[set_q] <= 1'b1;
    end
  end

  assign {rd_tags, rd_valid, rd_rank} = rd_flat;
  assign wr_flat = {new_tags, new_valid, new_rank};

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      reset_rank[w] = RANK_W'(w);
    end
    priority if (fwd) begin
      cur_tags  = row_tags;
      cur_valid = row_valid;
      cur_rank  = row_rank;
    end else if (row_init[set_q]) begin
      cur_tags  = rd_tags;
      cur_valid = rd_valid;
      cur_rank  = rd_rank;
    end else begin
      cur_tags  = rd_tags;   // don't care while invalid
      cur_valid = '0;
      cur_rank  = reset_rank;
    end
  end

  salru_way_sel #(
    .NUM_WAYS (NUM_WAYS),
    .RANK_W   (RANK_W),
    .NW_W     (NW_W)
  ) u_way_sel (
    .clk      (clk),
    .rst      (rst),
    .en       (look_en),
    .tags     (cur_tags),
    .valid    (cur_valid),
    .rank     (cur_rank),
    .tag      (tag_q),
    .ways_eff (ways_eff),
    .pick     (pick)
  );

  // ---------------- update and write-back ----------------
  assign pick_way  = pick.way[WAY_W-1:0];
  assign pick_rank = row_rank[pick_way];
  assign top_rank  = RANK_W'(ways_eff - NW_W'(1));

  always_comb begin
    new_tags  = row_tags;
    new_valid = row_valid;
    new_rank  = row_rank;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (NW_W'(w) < ways_eff && row_rank[w] > pick_rank) begin
        new_rank[w] = row_rank[w] - RANK_W'(1);
      end
    end
    new_rank[pick_way]  = top_rank;
    new_valid[pick_way] = 1'b1;
    new_tags[pick_way]  = tag_q;
  end

  // row register: holds the looked-up row, then the written one for forwarding
  always_ff @(posedge clk) begin
    if (look_en) begin
      row_tags  <= cur_tags;
      row_valid <= cur_valid;
      row_rank  <= cur_rank;
    end else if (mem_we) begin
      row_tags  <= new_tags;
      row_valid <= new_valid;
      row_rank  <= new_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      evict_cnt <= '0;
    end else if (done) begin
      unique case (pick.outcome)
        OC_HIT:  hit_cnt <= hit_cnt + COUNT_WIDTH'(1);
        OC_FILL: miss_cnt <= miss_cnt + COUNT_WIDTH'(1);
        OC_EVICT: begin
          miss_cnt  <= miss_cnt + COUNT_WIDTH'(1);
          evict_cnt <= evict_cnt + COUNT_WIDTH'(1);
        end
        default: ;
      endcase
    end
  end

  // Totals shown include this transaction
  always_comb begin
    res.outcome        = pick.outcome;
    res.last_of_run    = last_run;
    res.hit_total      = TOTAL_W'(hit_cnt + COUNT_WIDTH'(pick.outcome == OC_HIT));
    res.miss_total     = TOTAL_W'(miss_cnt + COUNT_WIDTH'(pick.outcome != OC_HIT));
    res.eviction_total = TOTAL_W'(evict_cnt + COUNT_WIDTH'(pick.outcome == OC_EVICT));
  end

  `SALRU_ASSERT(a_accept_look, accept |=> state == ST_LOOK && !done, "accept did not start lookup")
  `SALRU_ASSERT(a_modify_rehit, done && !res.last_of_run |-> ##2 (done && res.last_of_run &&
                res.outcome == OC_HIT), "second modify access did not hit")
  `SALRU_ASSERT(a_hit_count, done |=> (hit_cnt != $past(hit_cnt)) ==
                ($past(res.outcome) == OC_HIT), "hit counter out of step")
  `SALRU_ASSERT_ALWAYS(a_reset_idle, rst |=> state == ST_IDLE && !done, "not idle after reset")

endmodule
